/* hw/rtl/ppo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppo_pkg
// Shared types and constants for the perspective projection pipeline.
// ----------------------------------------------------------------------------
package ppo_pkg;

	localparam int CoordW = 32;
	localparam int RegW   = 31;
	localparam int CodeW  = 5;
	localparam int StatW  = 2;

	localparam logic [RegW-1:0] HalfWidthRst  = 31'd10485760;
	localparam logic [RegW-1:0] HalfHeightRst = 31'd6553600;

	typedef enum logic [0:0] {
		REG_HALF_WIDTH  = 1'b0,
		REG_HALF_HEIGHT = 1'b1
	} ppo_reg_t;

	typedef enum logic [StatW-1:0] {
		ST_PROJECTED = 2'd0,
		ST_BEHIND    = 2'd1,
		ST_OVERFLOW  = 2'd2
	} ppo_status_t;

	// Per-item state carried through the divider stages.
	typedef struct packed {
		logic [CodeW-1:0] codes;
		logic             behind;
		logic             ovf;
		logic             x_neg;
		logic             y_neg;
		logic [RegW-1:0]  z;
		logic [RegW-1:0]  rx;
		logic [RegW-1:0]  ry;
		logic [RegW-1:0]  qx;
		logic [RegW-1:0]  qy;
		logic [RegW-1:0]  mx;
		logic [RegW-1:0]  my;
	} ppo_div_t;

endpackage

/* hw/rtl/perspective_project_with_outcodes.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_project_with_outcodes
// Projects a view-space point to screen space and reports frustum outcodes.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | view_x, view_y, view_z
// out     | output    | out_valid/out_stall| clip_codes, screen_x, screen_y, status
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One item enters per cycle unless the output stalls; the pipeline has three front
// stages (outcodes and magnitudes, the two 32x31 multipliers, the overflow check),
// 31 divider stages producing one quotient bit each, and the output stage.
// Reset clears all valid bits and loads the default half canvas sizes.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module perspective_project_with_outcodes (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] view_x,
	input  logic [31:0] view_y,
	input  logic [31:0] view_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  clip_codes,
	output logic [31:0] screen_x,
	output logic [31:0] screen_y,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);
	import ppo_pkg::*;

	logic [RegW-1:0] half_width_q, half_height_q;
	logic            en;

	logic     dv [0:RegW];
	ppo_div_t dd [0:RegW];

	ppo_div_t    fin;
	logic [31:0] tx, ty;

	// The user must write configuration only while no item is in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= HalfWidthRst;
			half_height_q <= HalfHeightRst;
		end else if (cfg_we) begin
			unique case (ppo_reg_t'(cfg_index))
				REG_HALF_WIDTH:  half_width_q  <= cfg_data;
				REG_HALF_HEIGHT: half_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves as a whole unless the result at the output is held.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	ppo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_take  (in_valid),
		.x        (view_x),
		.y        (view_y),
		.z        (view_z),
		.hw       (half_width_q),
		.hh       (half_height_q),
		.valid_s3 (dv[0]),
		.data_s3  (dd[0])
	);

	// Quotient bits come out most significant first.
	for (genvar i = 0; i < RegW; i++) begin : g_div
		ppo_divstep #(.BIT(RegW - 1 - i)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_i  (dv[i]),
			.data_i   (dd[i]),
			.valid_s1 (dv[i+1]),
			.data_s1  (dd[i+1])
		);
	end

	assign fin = dd[RegW];
	assign tx  = fin.x_neg ? 32'd0 - {1'b0, fin.qx} : {1'b0, fin.qx};
	assign ty  = fin.y_neg ? 32'd0 - {1'b0, fin.qy} : {1'b0, fin.qy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv[RegW];
		end
	end

	// Behind wins over overflow; either one zeroes the screen position.
	always_ff @(posedge clk) begin
		if (en) begin
			clip_codes <= fin.codes;
			if (fin.behind) begin
				status   <= ST_BEHIND;
				screen_x <= '0;
				screen_y <= '0;
			end else if (fin.ovf) begin
				status   <= ST_OVERFLOW;
				screen_x <= '0;
				screen_y <= '0;
			end else begin
				status   <= ST_PROJECTED;
				screen_x <= {1'b0, half_width_q} + tx;
				screen_y <= {1'b0, half_height_q} - ty;
			end
		end
	end

`ifndef ASSERT_OFF
	a_behind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_BEHIND) == clip_codes[4]))
		else $error("behind status disagrees with outcode");
	a_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_PROJECTED) |-> (screen_x == '0 && screen_y == '0))
		else $error("unprojected item carries a position");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_PROJECTED || status == ST_BEHIND ||
		               status == ST_OVERFLOW))
		else $error("status code out of range");
`endif

endmodule

/* hw/rtl/ppo_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppo_front
// Outcodes, magnitudes, products and overflow check: three register stages.
// ----------------------------------------------------------------------------
module ppo_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_take,
	input  logic [31:0]             x,
	input  logic [31:0]             y,
	input  logic [31:0]             z,
	input  logic [30:0]             hw,
	input  logic [30:0]             hh,
	output logic                    valid_s3,
	output ppo_pkg::ppo_div_t       data_s3
);
	import ppo_pkg::*;

	logic [32:0]      xe, ye, ze, nze;
	logic [CodeW-1:0] codes_c;

	logic             valid_s1, valid_s2;
	logic [CodeW-1:0] codes_s1, codes_s2;
	logic             xn_s1, yn_s1, xn_s2, yn_s2;
	logic [31:0]      ax_s1, ay_s1;
	logic [RegW-1:0]  z_s1, z_s2;
	logic [62:0]      px_s2, py_s2;

	assign xe  = {x[31], x};
	assign ye  = {y[31], y};
	assign ze  = {z[31], z};
	assign nze = 33'd0 - ze;

	always_comb begin
		codes_c[0] = $signed(xe) > $signed(ze);
		codes_c[1] = $signed(ye) > $signed(ze);
		codes_c[2] = $signed(xe) < $signed(nze);
		codes_c[3] = $signed(ye) < $signed(nze);
		codes_c[4] = z[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			codes_s1 <= codes_c;
			xn_s1    <= x[31];
			yn_s1    <= y[31];
			ax_s1    <= x[31] ? 32'd0 - x : x;
			ay_s1    <= y[31] ? 32'd0 - y : y;
			z_s1     <= z[RegW-1:0];

			codes_s2 <= codes_s1;
			xn_s2    <= xn_s1;
			yn_s2    <= yn_s1;
			z_s2     <= z_s1;
			px_s2    <= {31'd0, ax_s1} * {32'd0, hw};
			py_s2    <= {31'd0, ay_s1} * {32'd0, hh};

			// Overflow when |product| >= z * 2^31, which also catches zero depth.
			data_s3.codes  <= codes_s2;
			data_s3.behind <= codes_s2[4];
			data_s3.ovf    <= (px_s2[62:31] >= {1'b0, z_s2}) ||
			                  (py_s2[62:31] >= {1'b0, z_s2});
			data_s3.x_neg  <= xn_s2;
			data_s3.y_neg  <= yn_s2;
			data_s3.z      <= z_s2;
			data_s3.rx     <= px_s2[61:31];
			data_s3.ry     <= py_s2[61:31];
			data_s3.qx     <= '0;
			data_s3.qy     <= '0;
			data_s3.mx     <= px_s2[30:0];
			data_s3.my     <= py_s2[30:0];
		end
	end

endmodule

/* hw/rtl/ppo_divstep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppo_divstep
// One restoring-division step for both lanes, producing quotient bit BIT.
// ----------------------------------------------------------------------------
module ppo_divstep #(
	parameter int BIT = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  ppo_pkg::ppo_div_t data_i,
	output logic              valid_s1,
	output ppo_pkg::ppo_div_t data_s1
);
	import ppo_pkg::*;

	logic [RegW:0] tx, ty, dx, dy;
	logic          gx, gy;
	ppo_div_t      nxt;

	always_comb begin
		tx  = {data_i.rx, data_i.mx[BIT]};
		ty  = {data_i.ry, data_i.my[BIT]};
		gx  = tx >= {1'b0, data_i.z};
		gy  = ty >= {1'b0, data_i.z};
		dx  = tx - {1'b0, data_i.z};
		dy  = ty - {1'b0, data_i.z};
		nxt = data_i;
		nxt.rx = gx ? dx[RegW-1:0] : tx[RegW-1:0];
		nxt.ry = gy ? dy[RegW-1:0] : ty[RegW-1:0];
		nxt.qx[BIT] = gx;
		nxt.qy[BIT] = gy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks perspective_project_with_outcodes against an in-bench prediction of
// the outcodes, the overflow-checked projection and the status field, with
// random gaps on both channels and several canvas size settings.
// ----------------------------------------------------------------------------

class projection_board;
	typedef struct {
		logic [4:0]  codes;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [1:0]  stat;
	} proj_t;

	proj_t pending[$];
	int errors = 0;
	logic [30:0] hw = ppo_pkg::HalfWidthRst;
	logic [30:0] hh = ppo_pkg::HalfHeightRst;

	// Signed multiply-divide with overflow check; returns 1 when it fits.
	static function bit scaled_div(longint a, longint b, longint c, output longint q);
		longint prod, mag;
		prod = a * b;
		mag = prod < 0 ? -prod : prod;
		q = 0;
		if (mag >= c * 64'sh80000000) return 0;
		q = prod / c;
		return 1;
	endfunction

	function void note_point(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
		longint x, y, z, nz, tx, ty;
		proj_t p;
		x = longint'($signed(vx));
		y = longint'($signed(vy));
		z = longint'($signed(vz));
		nz = -z;
		p.codes = {z < 0, y < nz, x < nz, y > z, x > z};
		p.sx = 0;
		p.sy = 0;
		if (z < 0) p.stat = ppo_pkg::ST_BEHIND;
		else if (scaled_div(x, longint'(hw), z, tx) && scaled_div(y, longint'(hh), z, ty)) begin
			p.sx = 32'(longint'(hw) + tx);
			p.sy = 32'(longint'(hh) - ty);
			p.stat = ppo_pkg::ST_PROJECTED;
		end else p.stat = ppo_pkg::ST_OVERFLOW;
		pending.push_back(p);
	endfunction

	function void check_result(logic [4:0] c, logic [31:0] sx, logic [31:0] sy, logic [1:0] st);
		proj_t p;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result codes=%h sx=%h sy=%h status=%0d",
				$realtime, c, sx, sy, st);
			errors++;
			return;
		end
		p = pending.pop_front();
		if (c !== p.codes) begin
			$display("%0t: clip_codes expected %h actual %h", $realtime, p.codes, c);
			errors++;
		end
		if (sx !== p.sx) begin
			$display("%0t: screen_x expected %h actual %h", $realtime, p.sx, sx);
			errors++;
		end
		if (sy !== p.sy) begin
			$display("%0t: screen_y expected %h actual %h", $realtime, p.sy, sy);
			errors++;
		end
		if (st !== p.stat) begin
			$display("%0t: status expected %0d actual %0d", $realtime, p.stat, st);
			errors++;
		end
	endfunction
endclass

module tb;
	import ppo_pkg::*;

	localparam int Latency = 35;
	localparam int WatchLimit = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [31:0] view_x = 0, view_y = 0, view_z = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [4:0] clip_codes;
	logic [31:0] screen_x, screen_y;
	logic [1:0] status;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [30:0] cfg_data = 0;

	projection_board board = new();
	int idle_cycles = 0;

	perspective_project_with_outcodes dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// The watchdog counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Output side: every accepted result is checked; stall is random per item.
	always @(posedge clk) begin
		if (out_valid && !out_stall && arst_n)
			board.check_result(clip_codes, screen_x, screen_y, status);
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
				if (gap > 0) begin
					out_stall <= 1;
					repeat (gap) @(posedge clk);
					out_stall <= 0;
				end
			end
		end
	end

	// Sends one point and waits until the block takes it.  The prediction is
	// noted at the accepting edge, so the config copy matches the block.  The
	// idle gap follows the item; with no gap, valid stays high for the next one,
	// so the caller drops valid before going quiet.
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit quiet);
		int gap;
		in_valid <= 1;
		view_x <= x;
		view_y <= y;
		view_z <= z;
		do @(posedge clk); while (in_stall);
		board.note_point(x, y, z);
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register writes happen only once the pipeline has drained.
	task automatic write_reg(ppo_reg_t idx, logic [30:0] val);
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (Latency) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_HALF_WIDTH) board.hw = val;
		else board.hh = val;
	endtask

	// Random point: often in front at moderate depth so that projection
	// succeeds, with full-range noise, zero depth and negative depth mixed in.
	task automatic random_point(bit quiet);
		logic [31:0] x, y, z;
		int kind;
		kind = $urandom_range(0, 9);
		x = $urandom();
		y = $urandom();
		z = $urandom();
		case (kind)
			0, 1, 2, 3: begin
				z = $urandom_range(32'h0001_0000, 32'h7fff_ffff);
				x = 32'($signed(z) >>> $urandom_range(0, 8));
				y = 32'($signed(z) >>> $urandom_range(0, 8));
				if ($urandom_range(0, 1)) x = -x;
				if ($urandom_range(0, 1)) y = -y;
			end
			4, 5: begin
				z = $urandom_range(1, 32'h7fff_ffff);
				x = $signed($urandom()) >>> $urandom_range(0, 31);
				y = $signed($urandom()) >>> $urandom_range(0, 31);
			end
			6: z = 0;
			7: z[31] = 1;
			default: ;
		endcase
		send_point(x, y, z, quiet);
	endtask

	initial begin
		logic [30:0] widths[5];
		logic [30:0] heights[5];
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed points under the reset sizes: origin, unit depth, zero
		// depth, most negative depth, the field extremes and overflow edges.
		send_point(0, 0, 32'h0001_0000, 1);
		send_point(32'h0001_0000, 32'hffff_0000, 32'h0001_0000, 1);
		send_point(32'h0002_0000, 32'hfffe_0000, 32'h0001_0000, 1);
		send_point(5, 7, 0, 1);
		send_point(0, 0, 0, 1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1);
		send_point(32'hffff_ffff, 1, 1, 1);
		send_point(32'h0000_00a0, 32'hffff_ff60, 1, 1);
		send_point(32'h0000_00a1, 0, 1, 1);
		send_point(32'h0000_0064, 32'h0000_0064, 32'h0000_0064, 0);
		send_point(32'hffff_ff9c, 32'hffff_ff9c, 32'h0000_0064, 0);
		send_point(0, 0, 32'hffff_ffff, 0);

		// Extremes of the canvas sizes, including wrap in the final add.
		write_reg(REG_HALF_WIDTH, 31'h7fff_ffff);
		write_reg(REG_HALF_HEIGHT, 31'h7fff_ffff);
		send_point(32'h3fff_ffff, 32'hc000_0001, 32'h7fff_ffff, 1);
		send_point(32'h7fff_ffff, 32'h8000_0001, 32'h7fff_ffff, 1);
		send_point(32'h0000_ffff, 32'hffff_0001, 32'h7fff_ffff, 1);
		write_reg(REG_HALF_WIDTH, 0);
		write_reg(REG_HALF_HEIGHT, 0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 0, 1);
		send_point(32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 1);

		widths = '{31'd10485760, 31'h7fff_ffff, 31'd0, 31'd1, 31'h2aaa_aaaa};
		heights = '{31'd6553600, 31'h7fff_ffff, 31'd0, 31'h5555_5555, 31'd1};
		for (int phase = 0; phase < 5; phase++) begin
			write_reg(REG_HALF_WIDTH, widths[phase]);
			write_reg(REG_HALF_HEIGHT, heights[phase]);
			for (int k = 0; k < 80; k++) random_point($urandom_range(0, 4) == 0);
		end
		// One setting drawn at random over the full range of cfg_data.
		write_reg(REG_HALF_WIDTH, 31'($urandom()));
		write_reg(REG_HALF_HEIGHT, 31'($urandom()));
		for (int k = 0; k < 20; k++) random_point(0);

		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (Latency + 5) @(posedge clk);
		if (board.errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/ppo_pkg.sv
hw/rtl/ppo_front.sv
hw/rtl/ppo_divstep.sv
hw/rtl/perspective_project_with_outcodes.sv
test/tb.sv
